// ===== src/scde_pkg.sv =====
// ----------------------------------------------------------------------------
// scde_pkg
// shared types, command codes and helpers of the display engine
// ----------------------------------------------------------------------------
package scde_pkg;

  // default framebuffer size
  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  // read word and padded row geometry
  localparam int WORD_W     = 64;
  localparam int FULL_COLS  = 2 * WORD_W;
  localparam int SPR_W      = 16;
  localparam int SHIFT_STEP = 4;

  // command codes
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_READ   = 3'd0;
  localparam cmd_t CMD_DRAW   = 3'd1;
  localparam cmd_t CMD_SCR_DN = 3'd2;
  localparam cmd_t CMD_SCR_RT = 3'd3;
  localparam cmd_t CMD_SCR_LT = 3'd4;
  localparam cmd_t CMD_LORES  = 3'd5;
  localparam cmd_t CMD_HIRES  = 3'd6;

  // control of the row store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } ram_ctl_t;

  // val modulo m for m >= 16, restoring reduction in four steps
  function automatic logic [7:0] mod_narrow(input logic [7:0] val, input logic [7:0] m);
    logic [10:0] v;
    logic [10:0] d;
    v = {3'b000, val};
    for (int k = 3; k >= 0; k--) begin
      d = {3'b000, m} << k;
      if (v >= d) begin
        v = v - d;
      end
    end
    return v[7:0];
  endfunction

endpackage

// ===== src/scde_in_if.sv =====
// ----------------------------------------------------------------------------
// scde_in_if
// command channel of the display engine, valid/ready with command payload
// ----------------------------------------------------------------------------
interface scde_in_if;
  import scde_pkg::*;

  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [3:0]  row_index;
  logic [15:0] sprite_row;
  logic [3:0]  scroll_lines;
  logic        word_index;

  modport source (
    output valid, cmd, pos_x, pos_y, row_index, sprite_row, scroll_lines, word_index,
    input  ready
  );

  modport sink (
    input  valid, cmd, pos_x, pos_y, row_index, sprite_row, scroll_lines, word_index,
    output ready
  );

endinterface

// ===== src/scde_out_if.sv =====
// ----------------------------------------------------------------------------
// scde_out_if
// result channel of the display engine, valid/ready with status payload
// ----------------------------------------------------------------------------
interface scde_out_if;

  logic        valid;
  logic        ready;
  logic        collision;
  logic [63:0] pixel_word;
  logic        hires;

  modport source (
    output valid, collision, pixel_word, hires,
    input  ready
  );

  modport sink (
    input  valid, collision, pixel_word, hires,
    output ready
  );

endinterface

// ===== src/scde_row_store.sv =====
// ----------------------------------------------------------------------------
// scde_row_store
// row-wide framebuffer memory, one write and two registered reads per cycle,
// per-row valid flags so that cleared rows read as zero
// ----------------------------------------------------------------------------
module scde_row_store #(
  parameter int ROWS = scde_pkg::MAX_ROWS_DEF,
  parameter int COLS = scde_pkg::MAX_COLS_DEF,
  localparam int AW  = $clog2(ROWS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scde_pkg::ram_ctl_t  ctl,
  input  logic [AW-1:0]       wr_addr,
  input  logic [COLS-1:0]     wr_data,
  input  logic [AW-1:0]       rd_addr_a,
  input  logic [AW-1:0]       rd_addr_b,
  output logic [COLS-1:0]     rd_data_a,
  output logic [COLS-1:0]     rd_data_b
);
  import scde_pkg::*;

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] vld_r;
  logic [COLS-1:0] rd_a_r;
  logic [COLS-1:0] rd_b_r;
  logic            va_r;
  logic            vb_r;

  // memory write and registered reads
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
      va_r   <= vld_r[rd_addr_a];
      vb_r   <= vld_r[rd_addr_b];
    end
  end

  // row valid flags, cleared at reset and on a full clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr_all) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // rows never written since the last clear read as blank
  assign rd_data_a = va_r ? rd_a_r : '0;
  assign rd_data_b = vb_r ? rd_b_r : '0;

endmodule

// ===== src/super_chip_display_engine_top.sv =====
// ----------------------------------------------------------------------------
// super_chip_display_engine_top
// super-chip style monochrome framebuffer: read, xor sprite row draw,
// scrolls and resolution switches over a row-wide memory
//
//   channel   dir   handshake          payload
//   in_chan   in    valid/ready        cmd, pos_x, pos_y, row_index,
//                                      sprite_row, scroll_lines, word_index
//   out_chan  out   valid/ready        collision, pixel_word, hires
//   cfg       in    cfg_we             cfg_wdata (clear on mode switch)
//
// one item at a time; a read fetches the row, picks the word and finishes, an
// in-area draw fetches the row, writes it back xored and finishes; a clipped
// draw, mode switch and unused codes go straight to the finish state; scrolls
// walk every active row at one row a cycle, from the last active row to row 0.
// the memory is single-write, dual-read with registered reads.
// reset and mode clears drop the per-row valid flags, so no clearing pass.
// a finished item waits while the output register holds an item not yet taken.
// ----------------------------------------------------------------------------
module super_chip_display_engine_top #(
  parameter int MAX_COLS = scde_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = scde_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  scde_in_if.sink     in_chan,
  scde_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import scde_pkg::*;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int HALF_COLS = MAX_COLS / 2;
  localparam int HALF_ROWS = MAX_ROWS / 2;
  localparam int EXT_W     = MAX_COLS + SPR_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RDW   = 3'd1;
  localparam logic [2:0] ST_DRAW  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                coll_r, coll_nxt;
  logic                hires_r, hires_nxt;
  logic                clr_cfg_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_coll_r, out_coll_nxt;
  logic                out_hires_r, out_hires_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  cmd_t                op_r, op_nxt;
  logic                half_r, half_nxt;
  logic [7:0]          x_r, x_nxt;
  logic [ROW_W-1:0]    y_r, y_nxt;
  logic [SPR_W-1:0]    sprite_r, sprite_nxt;
  logic [3:0]          n_r, n_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;

  logic                in_fire;
  logic [7:0]          w_act;
  logic [7:0]          h_act;
  logic [MAX_COLS-1:0] act_mask;
  logic [7:0]          x_mod;
  logic [7:0]          y_mod;
  logic [8:0]          y_draw;
  logic                draw_hit;
  logic [ROW_W-1:0]    rd_row;
  logic [ROW_W-1:0]    top_row;
  logic [EXT_W-1:0]    spr_ext;
  logic [MAX_COLS-1:0] draw_mask;
  logic [FULL_COLS-1:0] pad;
  logic [MAX_COLS-1:0] moved;

  ram_ctl_t            ram_ctl;
  logic [ROW_W-1:0]    wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [ROW_W-1:0]    rd_addr_a;
  logic [ROW_W-1:0]    rd_addr_b;
  logic [MAX_COLS-1:0] rd_data_a;
  logic [MAX_COLS-1:0] rd_data_b;

  scde_row_store #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ram_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // handshake
  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_fire            = in_chan.valid & in_chan.ready;
  assign out_chan.valid      = out_valid_r;
  assign out_chan.collision  = out_coll_r;
  assign out_chan.pixel_word = out_word_r;
  assign out_chan.hires      = out_hires_r;

  // active area of the current mode
  assign w_act    = hires_r ? 8'(MAX_COLS) : 8'(HALF_COLS);
  assign h_act    = hires_r ? 8'(MAX_ROWS) : 8'(HALF_ROWS);
  assign act_mask = hires_r ? {MAX_COLS{1'b1}} :
                    ~({MAX_COLS{1'b1}} >> HALF_COLS);

  // address decode of an incoming item
  assign x_mod    = mod_narrow(in_chan.pos_x, w_act);
  assign y_mod    = mod_narrow(in_chan.pos_y, h_act);
  assign y_draw   = {1'b0, y_mod} + 9'(in_chan.row_index);
  assign draw_hit = (y_draw < {1'b0, h_act});
  assign rd_row   = ROW_W'(mod_narrow(in_chan.pos_y, 8'(MAX_ROWS)));
  assign top_row  = ROW_W'(h_act - 8'd1);

  // sprite row placed at its column, column 0 at the msb
  assign spr_ext   = {sprite_r, {MAX_COLS{1'b0}}} >> x_r;
  assign draw_mask = spr_ext[EXT_W-1:SPR_W] & act_mask;

  // read row padded to two full words
  always_comb begin
    pad = '0;
    pad[FULL_COLS-1 -: MAX_COLS] = rd_data_a;
  end

  // active part of a row after a scroll
  always_comb begin
    unique case (op_r)
      CMD_SCR_DN: moved = (row_r >= ROW_W'(n_r)) ? rd_data_b : '0;
      CMD_SCR_RT: moved = (rd_data_a & act_mask) >> SHIFT_STEP;
      CMD_SCR_LT: moved = (rd_data_a & act_mask) << SHIFT_STEP;
      default:    moved = rd_data_a;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    coll_nxt      = coll_r;
    hires_nxt     = hires_r;
    word_nxt      = word_r;
    op_nxt        = op_r;
    half_nxt      = half_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    sprite_nxt    = sprite_r;
    n_nxt         = n_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_coll_nxt  = out_coll_r;
    out_hires_nxt = out_hires_r;
    out_word_nxt  = out_word_r;
    ram_ctl       = '0;
    wr_addr       = row_r;
    wr_data       = rd_data_a;
    rd_addr_a     = '0;
    rd_addr_b     = '0;

    // output register drains independently
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          word_nxt = '0;
          op_nxt   = in_chan.cmd;
          unique case (in_chan.cmd)
            CMD_READ: begin
              ram_ctl.rd_en = 1'b1;
              rd_addr_a     = rd_row;
              half_nxt      = in_chan.word_index;
              state_nxt     = ST_RDW;
            end
            CMD_DRAW: begin
              if (in_chan.row_index == 4'd0) begin
                coll_nxt = 1'b0;
              end
              x_nxt      = x_mod;
              y_nxt      = y_draw[ROW_W-1:0];
              sprite_nxt = in_chan.sprite_row;
              if (draw_hit) begin
                ram_ctl.rd_en = 1'b1;
                rd_addr_a     = y_draw[ROW_W-1:0];
                state_nxt     = ST_DRAW;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            CMD_SCR_DN, CMD_SCR_RT, CMD_SCR_LT: begin
              ram_ctl.rd_en = 1'b1;
              rd_addr_a     = top_row;
              rd_addr_b     = top_row - ROW_W'(in_chan.scroll_lines);
              row_nxt       = top_row;
              n_nxt         = in_chan.scroll_lines;
              state_nxt     = ST_SWEEP;
            end
            CMD_LORES, CMD_HIRES: begin
              ram_ctl.clr_all = clr_cfg_r;
              hires_nxt       = (in_chan.cmd == CMD_HIRES);
              state_nxt       = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // pick the requested half of the row
      ST_RDW: begin
        word_nxt  = half_r ? pad[WORD_W-1:0] : pad[FULL_COLS-1:WORD_W];
        state_nxt = ST_FIN;
      end

      // xor the sprite row in and note erased pixels
      ST_DRAW: begin
        ram_ctl.wr_en = 1'b1;
        wr_addr       = y_r;
        wr_data       = rd_data_a ^ draw_mask;
        if (|(rd_data_a & draw_mask)) begin
          coll_nxt = 1'b1;
        end
        state_nxt = ST_FIN;
      end

      // write back one row, fetch the one above it
      ST_SWEEP: begin
        ram_ctl.wr_en = 1'b1;
        wr_addr       = row_r;
        wr_data       = (rd_data_a & ~act_mask) | (moved & act_mask);
        if (row_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          ram_ctl.rd_en = 1'b1;
          rd_addr_a     = row_r - ROW_W'(1);
          rd_addr_b     = row_r - ROW_W'(1) - ROW_W'(n_r);
          row_nxt       = row_r - ROW_W'(1);
        end
      end

      // hand the item to the output register
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_coll_nxt  = coll_r;
          out_hires_nxt = hires_r;
          out_word_nxt  = word_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coll_r      <= 1'b0;
      hires_r     <= 1'b0;
      clr_cfg_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coll_r      <= coll_nxt;
      hires_r     <= hires_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        clr_cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_coll_r  <= out_coll_nxt;
    out_hires_r <= out_hires_nxt;
    out_word_r  <= out_word_nxt;
    word_r      <= word_nxt;
    op_r        <= op_nxt;
    half_r      <= half_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    sprite_r    <= sprite_nxt;
    n_r         <= n_nxt;
    row_r       <= row_nxt;
  end

`ifndef NO_ASSERTIONS
  // no memory write while waiting for an item
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_ctl.wr_en)
    else $error("framebuffer written while idle");

  // a full clear only comes with an accepted item
  a_clear_on_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_ctl.clr_all |-> in_fire)
    else $error("framebuffer cleared without an item");

  // the row sweep stays inside the active height
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (8'(row_r) < h_act))
    else $error("sweep row outside active area");

  // a finish with a free output register always delivers
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not delivered");
`endif

endmodule
